// ----- rtl/htfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_pkg: shared types and constants of the humidity/temperature decoder
// CRC-8 parameters, frame layout, scaling constants and the frame record
// that travels from the frame tracker to the scaling stage.
// ----------------------------------------------------------------------------
package htfd_pkg;

    // crc-8, msb first, no final xor
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;

    // frame layout
    localparam int         IDX_W      = 3;
    localparam int         RAW_W      = 20;
    localparam logic [2:0] IDX_STATUS = 3'd0;
    localparam logic [2:0] IDX_HUM_HI = 3'd1;
    localparam logic [2:0] IDX_HUM_MD = 3'd2;
    localparam logic [2:0] IDX_SPLIT  = 3'd3;
    localparam logic [2:0] IDX_TMP_MD = 3'd4;
    localparam logic [2:0] IDX_TMP_LO = 3'd5;
    localparam logic [2:0] IDX_CRC    = 3'd6;
    localparam logic [2:0] IDX_BAD    = 3'd7;

    // output scaling
    localparam int HUM_W  = 14;
    localparam int TMP_W  = 15;
    localparam logic [HUM_W-1:0] HUM_SCALE  = 14'd10000;
    localparam logic [TMP_W-1:0] TMP_SCALE  = 15'd20000;
    localparam logic [TMP_W-1:0] TMP_OFFSET = 15'd5000;

    // completed frame handed to the scaling stage
    typedef struct packed {
        logic             crc_ok;
        logic [RAW_W-1:0] hum_raw;
        logic [RAW_W-1:0] tmp_raw;
    } t_frame;

    // one byte through the crc, eight shift steps
    function automatic logic [7:0] crc_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++) begin
            if (c[7]) begin
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[6:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/humidity_temperature_frame_decoder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder: crc-checked sensor frame decoder
// Decodes seven-byte humidity/temperature sensor responses into a crc flag
// and scaled humidity and temperature readings.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready) takes one response byte per transfer,
//   with i_frame_start high on the status byte of each frame. Bytes 0 to 5
//   produce no result; byte 6 (the crc byte) produces one result transfer on
//   the output channel (o_valid / i_ready).
//   One byte is taken every cycle while o_ready is high. The frame register
//   captures the checked raw fields at the edge that takes the crc byte, and
//   the result register, which drives o_valid, captures the scaled values
//   once it is empty or i_ready is high; one constant multiply per reading.
//   When the receiver stalls, a pending result waits in the result register
//   and a second one in the frame register; once both are full o_ready
//   drops for every byte until i_ready returns high.
//   On a crc mismatch o_crc_ok is low and both readings are zero.
//   Reset is synchronous, active low: the byte position returns to the
//   status byte, the crc to its initial value and both stages empty.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder
    import htfd_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_frame_start,
    output logic                    o_valid,
    input  logic                    i_ready,
    output logic                    o_crc_ok,
    output logic [HUM_W-1:0]        o_humidity_centi,
    output logic signed [TMP_W-1:0] o_temperature_centi
);

    localparam int HUM_PROD_W = RAW_W + HUM_W;
    localparam int TMP_PROD_W = RAW_W + TMP_W;

    logic   w_take;
    logic   w_last;
    t_frame w_frame;
    logic   w_out_adv;
    logic   w_s1_free;

    logic   r_s1_valid;
    t_frame r_s1;
    logic   r_out_valid;
    logic   r_crc_ok;
    logic [HUM_W-1:0] r_hum;
    logic [TMP_W-1:0] r_tmp;

    logic [HUM_PROD_W-1:0] w_hum_prod;
    logic [TMP_PROD_W-1:0] w_tmp_prod;
    logic [HUM_W-1:0]      n_hum;
    logic [TMP_W-1:0]      n_tmp;

    // handshake: a byte is taken only while a frame slot is free
    assign w_out_adv = !r_out_valid || i_ready;
    assign w_s1_free = !r_s1_valid || w_out_adv;
    assign o_ready   = w_s1_free;
    assign w_take    = i_valid && o_ready;

    // byte tracking and crc
    htfd_frame u_frame (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_take        (w_take),
        .i_rx_byte     (i_rx_byte),
        .i_frame_start (i_frame_start),
        .o_last        (w_last),
        .o_frame       (w_frame)
    );

    // frame register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_take && w_last;
        end
    end

    // frame register payload
    always_ff @(posedge i_clk) begin
        if (w_take && w_last) begin
            r_s1 <= w_frame;
        end
    end

    // constant scaling, zero on crc failure
    assign w_hum_prod = HUM_PROD_W'(r_s1.hum_raw) * HUM_PROD_W'(HUM_SCALE);
    assign w_tmp_prod = TMP_PROD_W'(r_s1.tmp_raw) * TMP_PROD_W'(TMP_SCALE);
    always_comb begin
        n_hum = '0;
        n_tmp = '0;
        if (r_s1.crc_ok) begin
            n_hum = w_hum_prod[HUM_PROD_W-1:RAW_W];
            n_tmp = w_tmp_prod[TMP_PROD_W-1:RAW_W] - TMP_OFFSET;
        end
    end

    // result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    // result register payload
    always_ff @(posedge i_clk) begin
        if (w_out_adv && r_s1_valid) begin
            r_crc_ok <= r_s1.crc_ok;
            r_hum    <= n_hum;
            r_tmp    <= n_tmp;
        end
    end

    assign o_valid             = r_out_valid;
    assign o_crc_ok            = r_crc_ok;
    assign o_humidity_centi    = r_hum;
    assign o_temperature_centi = $signed(r_tmp);

endmodule

// ----- rtl/htfd_frame.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// htfd_frame: frame position, running crc and raw field capture
// Tracks the byte position, folds bytes 0 to 5 into the crc and assembles
// the two 20-bit raw fields; flags the crc byte and presents the frame.
// ----------------------------------------------------------------------------
module htfd_frame
    import htfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic [7:0] i_rx_byte,
    input  logic       i_frame_start,
    output logic       o_last,
    output t_frame     o_frame
);

    logic [IDX_W-1:0] r_idx, n_idx;
    logic [7:0]       r_crc, n_crc;
    logic [RAW_W-1:0] r_hum_raw, n_hum_raw;
    logic [RAW_W-1:0] r_tmp_raw, n_tmp_raw;

    logic [IDX_W-1:0] w_idx;
    logic [7:0]       w_crc;
    logic             w_restart;

    // restart on frame start or on an impossible position
    assign w_restart = i_frame_start || (r_idx == IDX_BAD);
    assign w_idx     = w_restart ? IDX_STATUS : r_idx;
    assign w_crc     = w_restart ? CRC_INIT : r_crc;

    // crc byte completes the frame
    assign o_last          = (w_idx == IDX_CRC);
    assign o_frame.crc_ok  = (w_crc == i_rx_byte);
    assign o_frame.hum_raw = r_hum_raw;
    assign o_frame.tmp_raw = r_tmp_raw;

    // next position, crc and raw fields
    always_comb begin
        n_idx     = r_idx;
        n_crc     = r_crc;
        n_hum_raw = r_hum_raw;
        n_tmp_raw = r_tmp_raw;
        if (i_take) begin
            if (o_last) begin
                n_idx = IDX_STATUS;
                n_crc = CRC_INIT;
            end else begin
                n_idx = w_idx + 3'd1;
                n_crc = crc_update(w_crc, i_rx_byte);
                case (w_idx)
                    IDX_HUM_HI: begin
                        n_hum_raw = {i_rx_byte, 12'd0};
                    end
                    IDX_HUM_MD: begin
                        n_hum_raw = {r_hum_raw[19:12], i_rx_byte, 4'd0};
                    end
                    IDX_SPLIT: begin
                        n_hum_raw = {r_hum_raw[19:4], i_rx_byte[7:4]};
                        n_tmp_raw = {i_rx_byte[3:0], 16'd0};
                    end
                    IDX_TMP_MD: begin
                        n_tmp_raw = {r_tmp_raw[19:16], i_rx_byte, 8'd0};
                    end
                    IDX_TMP_LO: begin
                        n_tmp_raw = {r_tmp_raw[19:8], i_rx_byte};
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= IDX_STATUS;
            r_crc <= CRC_INIT;
        end else begin
            r_idx <= n_idx;
            r_crc <= n_crc;
        end
    end

    // raw field payload
    always_ff @(posedge i_clk) begin
        r_hum_raw <= n_hum_raw;
        r_tmp_raw <= n_tmp_raw;
    end

endmodule

// ----- test/humidity_temperature_frame_decoder_chk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_chk: decoder scoreboard
// Watches both channels of the frame decoder. It tracks the byte position,
// crc and raw fields of every byte transfer, predicts the reading that each
// crc byte produces, and compares every result transfer with the oldest
// predicted reading, field by field.
// ----------------------------------------------------------------------------
package htfd_tb_pkg;

    import htfd_pkg::*;

    // crc-8 over one byte, fed bit by bit, msb first
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] acc;
        logic       fb;
        acc = crc;
        for (int i = 7; i >= 0; i--) begin
            fb  = acc[7] ^ data[i];
            acc = {acc[6:0], 1'b0} ^ (fb ? CRC_POLY : 8'h00);
        end
        return acc;
    endfunction

endpackage

module humidity_temperature_frame_decoder_chk
    import htfd_pkg::*;
    import htfd_tb_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    i_in_ready,
    input  logic [7:0]              i_rx_byte,
    input  logic                    i_frame_start,
    input  logic                    i_out_valid,
    input  logic                    i_out_ready,
    input  logic                    i_crc_ok,
    input  logic [HUM_W-1:0]        i_humidity_centi,
    input  logic signed [TMP_W-1:0] i_temperature_centi,
    output int                      o_fail_count,
    output int                      o_pending
);

    typedef struct packed {
        logic                    crc_ok;
        logic [HUM_W-1:0]        humidity;
        logic signed [TMP_W-1:0] temperature;
    } t_reading;

    t_reading         expected_readings[$];
    logic [IDX_W-1:0] byte_pos;
    logic [7:0]       crc_acc;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] tmp_raw;
    int               mismatches;

    // compare result transfers, then track the byte transfer of this edge
    always @(posedge i_clk) begin : track_frames
        t_reading         got;
        t_reading         want;
        t_reading         pred;
        logic [IDX_W-1:0] pos;
        logic [7:0]       crc;
        logic [7:0]       b;
        logic [63:0]      hum_scaled;
        logic [63:0]      tmp_scaled;
        if (!i_rst_n) begin
            byte_pos <= IDX_STATUS;
            crc_acc  <= CRC_INIT;
            hum_raw  <= '0;
            tmp_raw  <= '0;
            expected_readings.delete();
        end else begin
            // result side
            if (i_out_valid && i_out_ready) begin
                got = '{i_crc_ok, i_humidity_centi, i_temperature_centi};
                if (expected_readings.size() == 0) begin
                    $display("%0t: result with no reading expected: crc_ok %0d hum %0d tmp %0d",
                             $time, got.crc_ok, got.humidity, got.temperature);
                    mismatches++;
                end else begin
                    want = expected_readings.pop_front();
                    if (got.crc_ok !== want.crc_ok) begin
                        $display("%0t: crc_ok expected %0d actual %0d",
                                 $time, want.crc_ok, got.crc_ok);
                        mismatches++;
                    end
                    if (got.humidity !== want.humidity) begin
                        $display("%0t: humidity_centi expected %0d actual %0d",
                                 $time, want.humidity, got.humidity);
                        mismatches++;
                    end
                    if (got.temperature !== want.temperature) begin
                        $display("%0t: temperature_centi expected %0d actual %0d",
                                 $time, want.temperature, got.temperature);
                        mismatches++;
                    end
                end
            end

            // byte side
            if (i_in_valid && i_in_ready) begin
                pos = byte_pos;
                crc = crc_acc;
                b   = i_rx_byte;
                if (i_frame_start || pos == IDX_BAD) begin
                    pos = IDX_STATUS;
                    crc = CRC_INIT;
                end
                if (pos == IDX_CRC) begin
                    pred = '0;
                    pred.crc_ok = (crc == b);
                    if (pred.crc_ok) begin
                        hum_scaled       = (64'(hum_raw) * 64'(HUM_SCALE)) >> RAW_W;
                        tmp_scaled       = ((64'(tmp_raw) * 64'(TMP_SCALE)) >> RAW_W)
                                           - 64'(TMP_OFFSET);
                        pred.humidity    = hum_scaled[HUM_W-1:0];
                        pred.temperature = tmp_scaled[TMP_W-1:0];
                    end
                    expected_readings.push_back(pred);
                    byte_pos <= IDX_STATUS;
                    crc_acc  <= CRC_INIT;
                end else begin
                    crc_acc <= crc8_feed(crc, b);
                    case (pos)
                        IDX_HUM_HI: begin
                            hum_raw <= {b, 12'h000};
                        end
                        IDX_HUM_MD: begin
                            hum_raw <= {hum_raw[19:12], b, 4'h0};
                        end
                        IDX_SPLIT: begin
                            hum_raw <= {hum_raw[19:4], b[7:4]};
                            tmp_raw <= {b[3:0], 16'h0000};
                        end
                        IDX_TMP_MD: begin
                            tmp_raw <= {tmp_raw[19:16], b, 8'h00};
                        end
                        IDX_TMP_LO: begin
                            tmp_raw <= {tmp_raw[19:8], b};
                        end
                        default: begin
                        end
                    endcase
                    byte_pos <= pos + 1'b1;
                end
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_readings.size();
    end

endmodule

// ----- test/humidity_temperature_frame_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// humidity_temperature_frame_decoder_tb: frame decoder testbench
// Feeds sensor response frames (good, bad crc, truncated, noise) into the
// decoder under three idling mixes and a long receiver stall; a scoreboard
// beside the decoder predicts and checks each reading.
// ----------------------------------------------------------------------------
module humidity_temperature_frame_decoder_tb;

    import htfd_pkg::*;
    import htfd_tb_pkg::*;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_ready;
    logic [7:0]              i_rx_byte;
    logic                    i_frame_start;
    logic                    o_valid;
    logic                    i_ready;
    logic                    o_crc_ok;
    logic [HUM_W-1:0]        o_humidity_centi;
    logic signed [TMP_W-1:0] o_temperature_centi;

    int fail_count;
    int pending;
    int bytes_sent;
    int snd_idle_pct;
    int rcv_idle_pct;
    int stall_request;
    bit in_sync;

    humidity_temperature_frame_decoder dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_rx_byte           (i_rx_byte),
        .i_frame_start       (i_frame_start),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_crc_ok            (o_crc_ok),
        .o_humidity_centi    (o_humidity_centi),
        .o_temperature_centi (o_temperature_centi)
    );

    humidity_temperature_frame_decoder_chk chk (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_valid),
        .i_in_ready          (o_ready),
        .i_rx_byte           (i_rx_byte),
        .i_frame_start       (i_frame_start),
        .i_out_valid         (o_valid),
        .i_out_ready         (i_ready),
        .i_crc_ok            (o_crc_ok),
        .i_humidity_centi    (o_humidity_centi),
        .i_temperature_centi (o_temperature_centi),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // 50 MHz clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // run limit
    initial begin
        #2_000_000;
        $display("humidity_temperature_frame_decoder test failed");
        $finish;
    end

    // receiver: random stalls, plus long hold-offs on request
    always @(posedge i_clk) begin : receiver
        int hold_left;
        int stall_taken;
        if (stall_request != stall_taken) begin
            hold_left   = stall_request;
            stall_taken = stall_request;
        end
        if (hold_left > 0) begin
            i_ready <= 1'b0;
            hold_left--;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    // one byte transfer, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b, input logic start);
        while ($urandom_range(0, 99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_rx_byte     <= b;
        i_frame_start <= start;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // full seven-byte frame; payload holds bytes 1 to 5
    task automatic send_frame(input logic [7:0] status, input logic [39:0] payload,
                              input logic start, input logic bad_crc);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc8_feed(CRC_INIT, status);
        send_byte(status, start);
        for (int i = 4; i >= 0; i--) begin
            b   = payload[i*8 +: 8];
            crc = crc8_feed(crc, b);
            send_byte(b, 1'b0);
        end
        if (bad_crc) begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        send_byte(crc, 1'b0);
        in_sync = 1'b1;
    endtask

    // mostly well-formed frames, some bad crc, truncated frames and noise
    task automatic run_random(input int n_bytes);
        int          target;
        int          pick;
        int          len;
        logic [39:0] payload;
        target = bytes_sent + n_bytes;
        while (bytes_sent < target) begin
            pick    = $urandom_range(0, 99);
            payload = {8'($urandom), $urandom};
            if ($urandom_range(0, 19) == 0) begin
                payload = ($urandom_range(0, 1) != 0) ? '1 : '0;
            end
            if (pick < 70) begin
                send_frame(8'($urandom), payload,
                           !in_sync || ($urandom_range(0, 3) != 0), 1'b0);
            end else if (pick < 82) begin
                send_frame(8'($urandom), payload,
                           !in_sync || ($urandom_range(0, 3) != 0), 1'b1);
            end else if (pick < 90) begin
                // frame cut short, next one must resync
                len = $urandom_range(1, 6);
                send_byte(8'($urandom), 1'b1);
                for (int i = 1; i < len; i++) begin
                    send_byte(8'($urandom), 1'b0);
                end
                in_sync = 1'b0;
            end else begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++) begin
                    send_byte(8'($urandom), 1'($urandom_range(0, 1)));
                end
                in_sync = 1'b0;
            end
        end
    endtask

    // wait until every predicted reading has come back
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // stimulus and verdict
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_rx_byte     <= 8'h00;
        i_frame_start <= 1'b0;
        bytes_sent    = 0;
        stall_request = 0;
        in_sync       = 1'b0;
        snd_idle_pct  = 9;
        rcv_idle_pct  = 80;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // full-scale readings, then zero readings back to back without a start flag
        send_frame(8'h1C, 40'hFFFFF_FFFFF, 1'b1, 1'b0);
        send_frame(8'h00, 40'h00000_00000, 1'b0, 1'b0);
        // partial frame cut by a start flag, then a crc failure
        send_byte(8'hA5, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'h3C, 1'b0);
        send_frame(8'hFF, 40'h12345_6789A, 1'b1, 1'b1);
        run_random(260);
        drain();

        snd_idle_pct = 80;
        rcv_idle_pct = 9;
        run_random(280);
        drain();

        // no idling; one long receiver hold-off fills the decoder
        snd_idle_pct  = 0;
        rcv_idle_pct  = 0;
        stall_request = 300;
        run_random(290);
        drain();

        repeat (10) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("humidity_temperature_frame_decoder test passed");
        end else begin
            $display("humidity_temperature_frame_decoder test failed");
        end
        $finish;
    end

endmodule

// ----- humidity_temperature_frame_decoder.f -----
rtl/htfd_pkg.sv
rtl/htfd_frame.sv
rtl/humidity_temperature_frame_decoder.sv
test/humidity_temperature_frame_decoder_chk.sv
test/humidity_temperature_frame_decoder_tb.sv
